// ----- src/bone_pose_interpolate_macros.svh -----
// Assertion macros for the bone pose blend block.
`ifndef BONE_POSE_INTERPOLATE_MACROS_SVH
`define BONE_POSE_INTERPOLATE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define BPI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpi assertion failed");
// Next-cycle implication, sampled on clk, off during reset.
`define BPI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpi assertion failed");
`else
`define BPI_ASSERT_IMP(label, ante, cons)
`define BPI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- src/bpi_pkg.sv -----
// Shared types, constants and helpers for the bone pose blend pipeline.
`default_nettype none
package bpi_pkg;

    localparam int TRANS_W = 20;
    localparam int QUAT_W  = 16;
    localparam int PROG_W  = 17;
    localparam int MAG_W   = 31;   // |h| <= 2^30
    localparam int SUM_W   = 63;   // sum of four h^2 <= 2^62
    localparam int ROOT_W  = 32;
    localparam int QUO_W   = 15;   // quotient <= 16384
    localparam int NUM_W   = 46;   // m * 2^14 + r / 2

    localparam logic [PROG_W-1:0]        PROG_ONE = 17'h10000;
    localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;

    // Register stages of each section.
    localparam int BLEND_STAGES = 6;
    localparam int SQRT_STAGES  = 32;
    localparam int DIV_STAGES   = QUO_W + 2;
    localparam int LERP_STAGES  = 3;
    localparam int PIPE_DEPTH   = BLEND_STAGES + SQRT_STAGES + DIV_STAGES;

    typedef logic signed [TRANS_W-1:0] trans_t;
    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic [PROG_W-1:0]         prog_t;

    // Per-item data that rides alongside the root and divide stages.
    typedef struct packed {
        logic [3:0][MAG_W-1:0] mag;
        logic [3:0]            neg;
        logic                  zero;
    } bpi_side_t;

    typedef struct packed {
        trans_t out_x;
        trans_t out_y;
        trans_t out_z;
        quat_t  rot_w;
        quat_t  rot_x;
        quat_t  rot_y;
        quat_t  rot_z;
    } bpi_res_t;

    function automatic prog_t clamp_prog(input prog_t p);
        return (p > PROG_ONE) ? PROG_ONE : p;
    endfunction

endpackage
`default_nettype wire

// ----- src/bpi_if.sv -----
// Valid/ready channel interfaces for pose input and blended pose output.
`default_nettype none
interface bpi_in_if import bpi_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [59:0]         first_translation;
    logic [59:0]         second_translation;
    quat_t               a_w;
    quat_t               a_x;
    quat_t               a_y;
    quat_t               a_z;
    quat_t               b_w;
    quat_t               b_x;
    quat_t               b_y;
    quat_t               b_z;
    prog_t               progression;

    modport source (output valid, first_translation, second_translation,
                    a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, progression,
                    input ready);
    modport sink   (input valid, first_translation, second_translation,
                    a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, progression,
                    output ready);
endinterface

interface bpi_out_if import bpi_pkg::*; ();
    logic   valid;
    logic   ready;
    trans_t out_x;
    trans_t out_y;
    trans_t out_z;
    quat_t  rot_w;
    quat_t  rot_x;
    quat_t  rot_y;
    quat_t  rot_z;

    modport source (output valid, out_x, out_y, out_z, rot_w, rot_x, rot_y, rot_z,
                    input ready);
    modport sink   (input valid, out_x, out_y, out_z, rot_w, rot_x, rot_y, rot_z,
                    output ready);
endinterface
`default_nettype wire

// ----- src/bpi_lerp.sv -----
// Translation lerp per axis with rounding and saturation, delayed to pipe depth.
`default_nettype none
module bpi_lerp import bpi_pkg::*; (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [59:0] first_translation,
    input  wire logic [59:0] second_translation,
    input  wire prog_t       progression,
    output trans_t           out_x,
    output trans_t           out_y,
    output trans_t           out_z
);
    // line_reg[0] is the third lerp stage; the rest pad out to the rotation path
    localparam int DELAY = PIPE_DEPTH - LERP_STAGES + 1;

    trans_t res [3];
    prog_t  p1_reg;
    prog_t  p_cl;

    assign p_cl = clamp_prog(progression);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg <= p_cl;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_axis
        trans_t              a_in;
        trans_t              b_in;
        logic signed [20:0]  d;
        trans_t              a1_reg;
        logic                neg1_reg;
        logic [20:0]         mag1_reg;
        trans_t              a2_reg;
        logic                neg2_reg;
        logic [37:0]         prod2_reg;
        logic [38:0]         rnd;
        logic [22:0]         q;
        logic signed [23:0]  v;
        trans_t              sat;
        trans_t              line_reg [DELAY];

        assign a_in = trans_t'(first_translation[TRANS_W*i +: TRANS_W]);
        assign b_in = trans_t'(second_translation[TRANS_W*i +: TRANS_W]);
        assign d    = 21'(b_in) - 21'(a_in);

        assign rnd = 39'(prod2_reg) + 39'd32768;
        assign q   = rnd[38:16];
        assign v   = 24'(a2_reg) + (neg2_reg ? -$signed({1'b0, q}) : $signed({1'b0, q}));

        always_comb
        begin
            if (v > 24'sd524287)
                sat = 20'sh7FFFF;
            else if (v < -24'sd524288)
                sat = 20'sh80000;
            else
                sat = v[19:0];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                a1_reg    <= a_in;
                neg1_reg  <= d[20];
                mag1_reg  <= d[20] ? 21'(-d) : 21'(d);
                a2_reg    <= a1_reg;
                neg2_reg  <= neg1_reg;
                prod2_reg <= 38'(mag1_reg) * 38'(p1_reg);
                line_reg[0] <= sat;
                for (int s = 1; s < DELAY; s++)
                    line_reg[s] <= line_reg[s-1];
            end
        end

        assign res[i] = line_reg[DELAY-1];
    end

    assign out_x = res[0];
    assign out_y = res[1];
    assign out_z = res[2];

endmodule
`default_nettype wire

// ----- src/bpi_blend.sv -----
// Dot product, shortest-path flip, quaternion blend and squared length.
`default_nettype none
module bpi_blend import bpi_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       en,
    input  wire logic       in_valid,
    input  wire quat_t      a_w,
    input  wire quat_t      a_x,
    input  wire quat_t      a_y,
    input  wire quat_t      a_z,
    input  wire quat_t      b_w,
    input  wire quat_t      b_x,
    input  wire quat_t      b_y,
    input  wire quat_t      b_z,
    input  wire prog_t      progression,
    output logic            out_valid,
    output logic [SUM_W-1:0] sum,
    output bpi_side_t       side
);
    quat_t qa [4];
    quat_t qb [4];
    prog_t p_cl;

    logic [BLEND_STAGES-1:0] v_reg;

    // stage 1: clamp, pairwise products for the dot
    logic signed [31:0] prod1_reg [4];
    quat_t              a1_reg [4];
    quat_t              b1_reg [4];
    prog_t              p1_reg;
    prog_t              pa1_reg;
    // stage 2: dot sign, flip b
    logic signed [33:0] dot;
    quat_t              a2_reg [4];
    logic signed [16:0] bn2_reg [4];
    prog_t              p2_reg;
    prog_t              pa2_reg;
    // stage 3: weighted products
    logic signed [33:0] ca3_reg [4];
    logic signed [34:0] cb3_reg [4];
    // stage 4: halve toward zero, magnitude
    logic signed [35:0] c4 [4];
    logic signed [35:0] h4 [4];
    logic signed [35:0] m4 [4];
    bpi_side_t          side4_reg;
    // stage 5: squares
    logic [61:0]        sq5_reg [4];
    bpi_side_t          side5_reg;
    // stage 6: sum
    logic [63:0]        tot;
    logic [SUM_W-1:0]   sum6_reg;
    bpi_side_t          side6_reg;

    assign qa[0] = a_w;  assign qa[1] = a_x;  assign qa[2] = a_y;  assign qa[3] = a_z;
    assign qb[0] = b_w;  assign qb[1] = b_x;  assign qb[2] = b_y;  assign qb[3] = b_z;
    assign p_cl  = clamp_prog(progression);

    assign dot = 34'(prod1_reg[0]) + 34'(prod1_reg[1]) + 34'(prod1_reg[2])
               + 34'(prod1_reg[3]);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            c4[i] = 36'(ca3_reg[i]) + 36'(cb3_reg[i]);
            h4[i] = (c4[i] >>> 1) + ((c4[i][35] && c4[i][0]) ? 36'sd1 : 36'sd0);
            m4[i] = h4[i][35] ? -h4[i] : h4[i];
        end
    end

    assign tot = 64'(sq5_reg[0]) + 64'(sq5_reg[1]) + 64'(sq5_reg[2]) + 64'(sq5_reg[3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[BLEND_STAGES-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= p_cl;
            pa1_reg <= PROG_ONE - p_cl;
            p2_reg  <= p1_reg;
            pa2_reg <= pa1_reg;
            for (int i = 0; i < 4; i++)
            begin
                prod1_reg[i] <= qa[i] * qb[i];
                a1_reg[i]    <= qa[i];
                b1_reg[i]    <= qb[i];
                a2_reg[i]    <= a1_reg[i];
                bn2_reg[i]   <= dot[33] ? -17'(b1_reg[i]) : 17'(b1_reg[i]);
                ca3_reg[i]   <= $signed({1'b0, pa2_reg}) * a2_reg[i];
                cb3_reg[i]   <= $signed({1'b0, p2_reg}) * bn2_reg[i];
                side4_reg.mag[i] <= m4[i][MAG_W-1:0];
                side4_reg.neg[i] <= h4[i][35];
                sq5_reg[i]   <= 62'(side4_reg.mag[i]) * 62'(side4_reg.mag[i]);
            end
            side4_reg.zero <= 1'b0;
            side5_reg      <= side4_reg;
            sum6_reg       <= tot[SUM_W-1:0];
            side6_reg.mag  <= side5_reg.mag;
            side6_reg.neg  <= side5_reg.neg;
            side6_reg.zero <= (tot == '0);
        end
    end

    assign out_valid = v_reg[BLEND_STAGES-1];
    assign sum       = sum6_reg;
    assign side      = side6_reg;

endmodule
`default_nettype wire

// ----- src/bpi_isqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module bpi_isqrt import bpi_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [SUM_W-1:0]  sum,
    input  wire bpi_side_t         side_in,
    output logic                   out_valid,
    output logic [ROOT_W-1:0]      root,
    output bpi_side_t              side_out
);
    logic [63:0]  x_reg [SQRT_STAGES];
    logic [63:0]  r_reg [SQRT_STAGES];
    bpi_side_t    s_reg [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] v_reg;

    for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STAGES - 1 - j));
        logic [63:0] x_in;
        logic [63:0] r_in;
        logic [63:0] trial;
        logic        take;
        bpi_side_t   s_in;
        logic        v_in;

        if (j == 0) begin : g_first
            assign x_in = 64'(sum);
            assign r_in = '0;
            assign s_in = side_in;
            assign v_in = in_valid;
        end else begin : g_rest
            assign x_in = x_reg[j-1];
            assign r_in = r_reg[j-1];
            assign s_in = s_reg[j-1];
            assign v_in = v_reg[j-1];
        end

        assign trial = r_in + BIT;
        assign take  = (x_in >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[j] <= take ? (x_in - trial) : x_in;
                r_reg[j] <= take ? ((r_in >> 1) + BIT) : (r_in >> 1);
                s_reg[j] <= s_in;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STAGES-1];
    assign root      = r_reg[SQRT_STAGES-1][ROOT_W-1:0];
    assign side_out  = s_reg[SQRT_STAGES-1];

endmodule
`default_nettype wire

// ----- src/bpi_div.sv -----
// Four-lane restoring divide h*16384/root with rounding, sign and identity fixup.
`default_nettype none
module bpi_div import bpi_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic              in_valid,
    input  wire logic [ROOT_W-1:0] root,
    input  wire bpi_side_t         side_in,
    output logic                   out_valid,
    output logic [3:0][QUAT_W-1:0] rot
);
    // prep stage
    logic [3:0][NUM_W-1:0] num0_reg;
    logic [ROOT_W-1:0]     root0_reg;
    logic [3:0]            neg0_reg;
    logic                  zero0_reg;
    logic                  v0_reg;
    // quotient stages
    logic [3:0][NUM_W-1:0] rem_reg  [QUO_W];
    logic [3:0][QUO_W-1:0] quo_reg  [QUO_W];
    logic [ROOT_W-1:0]     root_reg [QUO_W];
    logic [3:0]            neg_reg  [QUO_W];
    logic                  zero_reg [QUO_W];
    logic [QUO_W-1:0]      v_reg;
    // final stage
    logic [3:0][QUAT_W-1:0] rot_reg;
    logic                   vf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            vf_reg <= v_reg[QUO_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
                num0_reg[l] <= NUM_W'({side_in.mag[l], 14'b0}) + NUM_W'(root >> 1);
            root0_reg <= root;
            neg0_reg  <= side_in.neg;
            zero0_reg <= side_in.zero;
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int K = QUO_W - 1 - j;
        logic [3:0][NUM_W-1:0] rem_in;
        logic [3:0][QUO_W-1:0] quo_in;
        logic [ROOT_W-1:0]     root_in;
        logic [3:0]            neg_in;
        logic                  zero_in;
        logic                  v_in;
        logic [NUM_W-1:0]      dv;
        logic [3:0][NUM_W-1:0] rem_next;
        logic [3:0][QUO_W-1:0] quo_next;

        if (j == 0) begin : g_first
            assign rem_in  = num0_reg;
            assign quo_in  = '0;
            assign root_in = root0_reg;
            assign neg_in  = neg0_reg;
            assign zero_in = zero0_reg;
            assign v_in    = v0_reg;
        end else begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign root_in = root_reg[j-1];
            assign neg_in  = neg_reg[j-1];
            assign zero_in = zero_reg[j-1];
            assign v_in    = v_reg[j-1];
        end

        assign dv = NUM_W'(root_in) << K;

        always_comb
        begin
            for (int l = 0; l < 4; l++)
            begin
                quo_next[l] = quo_in[l];
                if (rem_in[l] >= dv)
                begin
                    rem_next[l]    = rem_in[l] - dv;
                    quo_next[l][K] = 1'b1;
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (en)
                v_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                quo_reg[j]  <= quo_next;
                root_reg[j] <= root_in;
                neg_reg[j]  <= neg_in;
                zero_reg[j] <= zero_in;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 4; l++)
            begin
                if (zero_reg[QUO_W-1])
                    rot_reg[l] <= (l == 0) ? QUAT_ONE : '0;
                else if (neg_reg[QUO_W-1][l])
                    rot_reg[l] <= -$signed({1'b0, quo_reg[QUO_W-1][l]});
                else
                    rot_reg[l] <= {1'b0, quo_reg[QUO_W-1][l]};
            end
        end
    end

    assign out_valid = vf_reg;
    assign rot       = rot_reg;

endmodule
`default_nettype wire

// ----- src/bone_pose_interpolate.sv -----
// Top level of the bone pose blend pipeline with output skid stage.
//
// Usage:
//   pose_in  : valid/ready sink, one start/end pose pair plus progression
//              per transfer. Progression above 1.0 is clamped.
//   pose_out : valid/ready source, one blended pose per input transfer,
//              in input order.
// Throughput: one transfer per cycle while the skid register is empty.
// Path: an input transfer passes 6 blend stages,
//   32 square-root stages (one root bit each), 17 divide stages (prep,
//   15 quotient bits, sign/identity), then the output register.
//   Translation runs in 3 stages and is delayed to line up.
// Reset: rst_n clears all valid bits; the pipe comes up empty and ready.
// Stall: all stages advance together while the skid register is empty.
//   When the receiver stalls, the output register holds its result and
//   one more result lands in the skid register; ready then drops until
//   the skid drains. Nothing is lost or repeated.
`default_nettype none
`include "bone_pose_interpolate_macros.svh"
module bone_pose_interpolate import bpi_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bpi_in_if.sink     pose_in,
    bpi_out_if.source  pose_out
);
    logic en;

    logic             blend_valid;
    logic [SUM_W-1:0] blend_sum;
    bpi_side_t        blend_side;

    logic              root_valid;
    logic [ROOT_W-1:0] root;
    bpi_side_t         root_side;

    logic                   div_valid;
    logic [3:0][QUAT_W-1:0] rot;

    trans_t lerp_x;
    trans_t lerp_y;
    trans_t lerp_z;

    bpi_res_t pipe_res;
    logic     incoming;

    bpi_res_t out_reg;
    logic     out_valid_reg;
    bpi_res_t skid_reg;
    logic     skid_valid_reg;

    // whole pipe moves as one; a full skid freezes it
    assign en            = !skid_valid_reg;
    assign pose_in.ready = en;

    bpi_blend u_blend (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (pose_in.valid),
        .a_w         (pose_in.a_w),
        .a_x         (pose_in.a_x),
        .a_y         (pose_in.a_y),
        .a_z         (pose_in.a_z),
        .b_w         (pose_in.b_w),
        .b_x         (pose_in.b_x),
        .b_y         (pose_in.b_y),
        .b_z         (pose_in.b_z),
        .progression (pose_in.progression),
        .out_valid   (blend_valid),
        .sum         (blend_sum),
        .side        (blend_side)
    );

    bpi_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (blend_valid),
        .sum       (blend_sum),
        .side_in   (blend_side),
        .out_valid (root_valid),
        .root      (root),
        .side_out  (root_side)
    );

    bpi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (root_valid),
        .root      (root),
        .side_in   (root_side),
        .out_valid (div_valid),
        .rot       (rot)
    );

    bpi_lerp u_lerp (
        .clk                (clk),
        .en                 (en),
        .first_translation  (pose_in.first_translation),
        .second_translation (pose_in.second_translation),
        .progression        (pose_in.progression),
        .out_x              (lerp_x),
        .out_y              (lerp_y),
        .out_z              (lerp_z)
    );

    always_comb
    begin
        pipe_res.out_x = lerp_x;
        pipe_res.out_y = lerp_y;
        pipe_res.out_z = lerp_z;
        pipe_res.rot_w = rot[0];
        pipe_res.rot_x = rot[1];
        pipe_res.rot_y = rot[2];
        pipe_res.rot_z = rot[3];
    end

    // last pipe stage hands its item over on every enabled edge
    assign incoming = div_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pose_out.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= incoming;
            end
        end
        else if (incoming)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pose_out.ready)
            out_reg <= skid_valid_reg ? skid_reg : pipe_res;
        else if (incoming)
            skid_reg <= pipe_res;
    end

    assign pose_out.valid = out_valid_reg;
    assign pose_out.out_x = out_reg.out_x;
    assign pose_out.out_y = out_reg.out_y;
    assign pose_out.out_z = out_reg.out_z;
    assign pose_out.rot_w = out_reg.rot_w;
    assign pose_out.rot_x = out_reg.rot_x;
    assign pose_out.rot_y = out_reg.rot_y;
    assign pose_out.rot_z = out_reg.rot_z;

    // skid only fills behind a held result
    `BPI_ASSERT_IMP(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // a taken output with a full skid promotes the skid and empties it
    `BPI_ASSERT_NEXT(a_skid_drain, skid_valid_reg && pose_out.ready, !skid_valid_reg && out_valid_reg)
    // normalized rotation w and x components never exceed unit magnitude
    `BPI_ASSERT_IMP(a_rot_range, pose_out.valid, (out_reg.rot_w <= QUAT_ONE) && (out_reg.rot_w >= -QUAT_ONE) && (out_reg.rot_x <= QUAT_ONE) && (out_reg.rot_x >= -QUAT_ONE))

endmodule
`default_nettype wire

// ----- test/tb_bone_pose_interpolate.sv -----
// Testbench for the bone pose blend pipeline: directed table, random poses, self-checking.
`default_nettype none
module tb_bone_pose_interpolate;
    import bpi_pkg::*;

    localparam int  RANDOM_POSES = 550;
    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  DRAIN_CYCLES = 80;    // longer than the pipe latency
    localparam int  LONG_HOLD    = 400;   // receiver hold-off, cycles
    localparam int  HOLD_AT      = 120;   // received count that starts the hold-off
    localparam int  PAUSE_AT     = 320;   // random pose index where sender drains
    localparam longint PONE      = 65536;
    localparam longint QONE      = 16384;

    // One input pose pair.
    typedef struct {
        logic [59:0] first_t;
        logic [59:0] second_t;
        quat_t       qa [4];    // w, x, y, z
        quat_t       qb [4];
        prog_t       prog;
    } pose_req_t;

    // Directed row: typed rows carry their own expected pose.
    typedef struct {
        pose_req_t req;
        bit        typed;
        bpi_res_t  want;
    } pose_row_t;

    logic clk;
    logic rst_n;

    bpi_in_if  pose_in ();
    bpi_out_if pose_out ();

    bone_pose_interpolate u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .pose_in  (pose_in.sink),
        .pose_out (pose_out.source)
    );

    bpi_res_t  pending_poses [$];   // blended poses not yet seen at the output
    pose_row_t pose_table [$];
    int        mismatch_cnt;
    int        received_cnt;
    int        cycle_cnt;
    bit        stim_done;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic longint unsigned root_floor(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic bpi_res_t blend_pose(input pose_req_t rq);
        bpi_res_t        res;
        longint          p, a, b, d, v, dot, bi, c;
        longint          h [4];
        longint unsigned mag, q, sum, r;
        trans_t          ta, tb;
        trans_t          tout [3];
        quat_t           qout [4];
        p = (rq.prog > PROG_ONE) ? PONE : longint'(rq.prog);
        for (int i = 0; i < 3; i++)
        begin
            ta  = rq.first_t[20*i +: 20];
            tb  = rq.second_t[20*i +: 20];
            a   = ta;
            b   = tb;
            d   = b - a;
            mag = (d < 0) ? -d : d;
            q   = (mag * p + 32768) >> 16;
            v   = a + ((d < 0) ? -longint'(q) : longint'(q));
            if (v > 524287)
                v = 524287;
            if (v < -524288)
                v = -524288;
            tout[i] = trans_t'(v);
        end
        dot = 0;
        for (int i = 0; i < 4; i++)
            dot += longint'(rq.qa[i]) * longint'(rq.qb[i]);
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            bi   = (dot < 0) ? -longint'(rq.qb[i]) : longint'(rq.qb[i]);
            c    = (PONE - p) * longint'(rq.qa[i]) + p * bi;
            h[i] = c / 2;   // truncates toward zero
            mag  = (h[i] < 0) ? -h[i] : h[i];
            sum += mag * mag;
        end
        if (sum == 0)
        begin
            // zero-length blend falls back to identity
            qout[0] = quat_t'(QONE);
            qout[1] = '0;
            qout[2] = '0;
            qout[3] = '0;
        end
        else
        begin
            r = root_floor(sum);
            for (int i = 0; i < 4; i++)
            begin
                mag     = (h[i] < 0) ? -h[i] : h[i];
                q       = (mag * QONE + r / 2) / r;
                qout[i] = (h[i] < 0) ? quat_t'(-longint'(q)) : quat_t'(q);
            end
        end
        res.out_x = tout[0];
        res.out_y = tout[1];
        res.out_z = tout[2];
        res.rot_w = qout[0];
        res.rot_x = qout[1];
        res.rot_y = qout[2];
        res.rot_z = qout[3];
        return res;
    endfunction

    function automatic logic [59:0] pack_xyz(input trans_t x, input trans_t y, input trans_t z);
        return {z, y, x};
    endfunction

    function automatic pose_req_t make_pose(input logic [59:0] ft, input logic [59:0] st,
                                            input quat_t aw, input quat_t ax,
                                            input quat_t ay, input quat_t az,
                                            input quat_t bw, input quat_t bx,
                                            input quat_t by, input quat_t bz,
                                            input prog_t p);
        pose_req_t rq;
        rq.first_t  = ft;
        rq.second_t = st;
        rq.qa[0] = aw; rq.qa[1] = ax; rq.qa[2] = ay; rq.qa[3] = az;
        rq.qb[0] = bw; rq.qb[1] = bx; rq.qb[2] = by; rq.qb[3] = bz;
        rq.prog     = p;
        return rq;
    endfunction

    // Typed row: translation and rotation read straight off the inputs.
    function automatic void add_typed(input pose_req_t rq, input trans_t x, input trans_t y,
                                      input trans_t z, input quat_t w, input quat_t qx,
                                      input quat_t qy, input quat_t qz);
        pose_row_t row;
        row.req   = rq;
        row.typed = 1'b1;
        row.want  = '{out_x: x, out_y: y, out_z: z, rot_w: w, rot_x: qx, rot_y: qy,
                      rot_z: qz};
        pose_table.push_back(row);
    endfunction

    function automatic void add_predicted(input pose_req_t rq);
        pose_row_t row;
        row.req   = rq;
        row.typed = 1'b0;
        row.want  = '0;
        pose_table.push_back(row);
    endfunction

    // ---------------------------------------------------------------
    // Random poses
    // ---------------------------------------------------------------
    function automatic quat_t rand_comp(input bit wide);
        if (wide)
            return quat_t'($urandom_range(0, 65535));
        return quat_t'(int'($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic prog_t rand_prog();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return PROG_ONE;
            2:       return prog_t'($urandom_range(65537, 131071));    // clamped
            3:       return prog_t'($urandom_range(0, 131071));
            default: return prog_t'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic pose_req_t rand_pose();
        pose_req_t rq;
        int        kind;
        bit        wide;
        kind        = $urandom_range(0, 19);
        wide        = (kind >= 16);
        rq.first_t  = 60'({$urandom, $urandom});
        rq.second_t = 60'({$urandom, $urandom});
        for (int i = 0; i < 4; i++)
        begin
            rq.qa[i] = rand_comp(wide);
            rq.qb[i] = rand_comp(wide);
        end
        if (kind == 0)
        begin
            // opposite ends: shortest-path flip
            for (int i = 0; i < 4; i++)
                rq.qb[i] = -rq.qa[i];
        end
        else if (kind == 1)
        begin
            for (int i = 0; i < 4; i++)
            begin
                rq.qa[i] = '0;
                rq.qb[i] = '0;
            end
        end
        else if (kind == 2)
            rq.second_t = rq.first_t ^ 60'(1 << $urandom_range(0, 30));
        rq.prog = rand_prog();
        return rq;
    endfunction

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    task automatic send_pose(input pose_req_t rq, input bpi_res_t want, input int gap);
        if (gap > 0)
        begin
            pose_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pose_in.valid              <= 1'b1;
        pose_in.first_translation  <= rq.first_t;
        pose_in.second_translation <= rq.second_t;
        pose_in.a_w <= rq.qa[0]; pose_in.a_x <= rq.qa[1];
        pose_in.a_y <= rq.qa[2]; pose_in.a_z <= rq.qa[3];
        pose_in.b_w <= rq.qb[0]; pose_in.b_x <= rq.qb[1];
        pose_in.b_y <= rq.qb[2]; pose_in.b_z <= rq.qb[3];
        pose_in.progression <= rq.prog;
        do
            @(posedge clk);
        while (!pose_in.ready);
        pending_poses.push_back(want);
    endtask

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 16);
    endfunction

    initial
    begin
        pose_req_t rq;
        bit        burst;
        trans_t    tmax, tmin;
        quat_t     qone;
        tmax = 20'sh7ffff;
        tmin = 20'sh80000;
        qone = QUAT_ONE;

        rst_n         = 1'b0;
        stim_done     = 1'b0;
        pose_in.valid = 1'b0;
        pose_in.first_translation  = '0;
        pose_in.second_translation = '0;
        pose_in.a_w = '0; pose_in.a_x = '0; pose_in.a_y = '0; pose_in.a_z = '0;
        pose_in.b_w = '0; pose_in.b_x = '0; pose_in.b_y = '0; pose_in.b_z = '0;
        pose_in.progression = '0;

        // directed rows
        add_typed(make_pose('0, '0, 0, 0, 0, 0, 0, 0, 0, 0, '0),
                  0, 0, 0, qone, 0, 0, 0);
        add_typed(make_pose(pack_xyz(tmax, tmin, 0), pack_xyz(tmin, tmax, 1),
                            qone, 0, 0, 0, qone, 0, 0, 0, '0),
                  tmax, tmin, 0, qone, 0, 0, 0);
        add_typed(make_pose(pack_xyz(tmax, tmin, 0), pack_xyz(tmin, tmax, 1),
                            qone, 0, 0, 0, qone, 0, 0, 0, PROG_ONE),
                  tmin, tmax, 1, qone, 0, 0, 0);
        // progression above one is clamped
        add_typed(make_pose(pack_xyz(tmax, tmin, 0), pack_xyz(tmin, tmax, 1),
                            qone, 0, 0, 0, qone, 0, 0, 0, 17'h1ffff),
                  tmin, tmax, 1, qone, 0, 0, 0);
        add_typed(make_pose(pack_xyz(0, 5, -5), pack_xyz(tmin, tmax, 7),
                            0, qone, 0, 0, 0, qone, 0, 0, 17'h10001),
                  tmin, tmax, 7, 0, qone, 0, 0);
        // negative dot flips the end rotation
        add_typed(make_pose('0, '0, qone, 0, 0, 0, -qone, 0, 0, 0, 17'h08000),
                  0, 0, 0, qone, 0, 0, 0);
        // zero-length blends give identity
        add_typed(make_pose('0, '0, 0, 0, 0, 0, 0, 0, 0, 0, PROG_ONE),
                  0, 0, 0, qone, 0, 0, 0);
        add_typed(make_pose('0, '0, 0, 0, 0, 0, 0, 0, 0, 16'sh8000, '0),
                  0, 0, 0, qone, 0, 0, 0);
        add_predicted(make_pose(pack_xyz(tmin, tmin, tmin), pack_xyz(tmax, tmax, tmax),
                                16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 17'h08000));
        add_predicted(make_pose(pack_xyz(0, 0, 0), pack_xyz(1, -1, 3),
                                0, qone, 0, 0, 0, 0, qone, 0, 17'h08000));
        add_predicted(make_pose(pack_xyz(-1, -1, -1), '0,
                                16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                                16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 17'h04000));
        add_predicted(make_pose({60{1'b1}}, '0, -1, -1, -1, -1, 1, 1, 1, 1, 17'h0ffff));
        add_predicted(make_pose(pack_xyz(100, -100, 0), pack_xyz(-100, 100, 0),
                                11585, 0, 11585, 0, 11585, 11585, 0, 0, 17'h00001));
        add_predicted(make_pose(pack_xyz(3, 0, 0), pack_xyz(4, 0, 0),
                                0, 0, 0, 1, 0, 0, 0, 1, 17'h0aaaa));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (pose_table[i])
            send_pose(pose_table[i].req,
                      pose_table[i].typed ? pose_table[i].want : blend_pose(pose_table[i].req),
                      draw_gap(i % 5 == 0));

        burst = 1'b0;
        for (int i = 0; i < RANDOM_POSES; i++)
        begin
            if (i % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (i == PAUSE_AT)
            begin
                // let the pipe run dry before going on
                pose_in.valid <= 1'b0;
                while (pending_poses.size() != 0)
                    @(posedge clk);
            end
            rq = rand_pose();
            send_pose(rq, blend_pose(rq), draw_gap(burst));
        end
        pose_in.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // ---------------------------------------------------------------
    // Receiver: random ready, one long hold-off to back the pipe up
    // ---------------------------------------------------------------
    initial
    begin
        int  gap;
        bit  burst;
        bit  held;
        int  taken;
        pose_out.ready = 1'b0;
        burst = 1'b0;
        held  = 1'b0;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            gap = burst ? 0 : $urandom_range(0, 16);
            if (!held && taken >= HOLD_AT)
            begin
                held = 1'b1;
                gap  = LONG_HOLD;
            end
            if (gap > 0)
            begin
                pose_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pose_out.ready <= 1'b1;
            do
                @(posedge clk);
            while (!pose_out.valid);
            taken++;
        end
    end

    // ---------------------------------------------------------------
    // Output check against the oldest pending pose
    // ---------------------------------------------------------------
    task automatic report_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            if (mismatch_cnt < 10)
                $display("mismatch %0s at transfer %0d: expected %0d, got %0d",
                         name, received_cnt, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge clk)
    begin
        bpi_res_t want;
        if (rst_n && pose_out.valid && pose_out.ready)
        begin
            if (pending_poses.size() == 0)
            begin
                if (mismatch_cnt < 10)
                    $display("unexpected output transfer %0d", received_cnt);
                mismatch_cnt++;
            end
            else
            begin
                want = pending_poses.pop_front();
                report_field("out_x", want.out_x, pose_out.out_x);
                report_field("out_y", want.out_y, pose_out.out_y);
                report_field("out_z", want.out_z, pose_out.out_z);
                report_field("rot_w", want.rot_w, pose_out.rot_w);
                report_field("rot_x", want.rot_x, pose_out.rot_x);
                report_field("rot_y", want.rot_y, pose_out.rot_y);
                report_field("rot_z", want.rot_z, pose_out.rot_z);
            end
            received_cnt++;
        end
    end

    // ---------------------------------------------------------------
    // End of run and watchdog
    // ---------------------------------------------------------------
    initial
    begin
        mismatch_cnt = 0;
        received_cnt = 0;
        wait (stim_done);
        while (pending_poses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && pending_poses.size() == 0)
            $display("bone_pose_interpolate verification clean");
        else
            $display("bone_pose_interpolate verification failed");
        $finish;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt >= CYCLE_LIMIT)
            begin
                $display("bone_pose_interpolate verification failed");
                $finish;
            end
        end
    end

endmodule
`default_nettype wire

// ----- files.f -----
+incdir+src
src/bpi_pkg.sv
src/bpi_if.sv
src/bpi_lerp.sv
src/bpi_blend.sv
src/bpi_isqrt.sv
src/bpi_div.sv
src/bone_pose_interpolate.sv
test/tb_bone_pose_interpolate.sv
